// ===== rtl/plrc_pkg.sv =====
// shared types and constants for the pair-keyed lru cache
package plrc_pkg;

	localparam int KEY_W    = 64;
	localparam int ID_W     = 32;
	localparam int STAMP_W  = 32;

	// lookup request beat
	typedef struct packed {
		logic [ID_W-1:0] buffer_decl_id;
		logic [ID_W-1:0] shader_decl_id;
	} req_t;

	// lookup result beat
	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] layout_id;
		logic            pruned;
		logic            first_prune;
	} rsp_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_LOOKUP_WAIT,
		ST_DECIDE,
		ST_PRUNE,
		ST_PRUNE_WAIT,
		ST_EVICT,
		ST_COMMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;       // invalidate entry at scan address
		logic scan_init;   // restart scan address and trackers
		logic prune_mode;  // with scan_init: min-stamp search instead of lookup
		logic scan;        // read entry at scan address
		logic evict;       // drop the victim of the last prune pass
		logic commit;      // final table write and result beat
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic addr_last;
		logic hit;
		logic full;
		logic pass_last;
	} ctl_sts_t;

endpackage

// ===== rtl/plrc_ctrl.sv =====
// controller state machine for the pair-keyed lru cache
module plrc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  plrc_pkg::ctl_sts_t  sts,
	output plrc_pkg::ctl_cmd_t  cmd,
	output logic                busy
);
	import plrc_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.addr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.scan_init = 1'b1;
					state_nxt     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.scan = 1'b1;
				if (sts.addr_last) begin
					state_nxt = ST_LOOKUP_WAIT;
				end
			end
			ST_LOOKUP_WAIT: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!sts.hit && sts.full) begin
					cmd.scan_init  = 1'b1;
					cmd.prune_mode = 1'b1;
					state_nxt      = ST_PRUNE;
				end else begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_PRUNE: begin
				cmd.scan = 1'b1;
				if (sts.addr_last) begin
					state_nxt = ST_PRUNE_WAIT;
				end
			end
			ST_PRUNE_WAIT: begin
				state_nxt = ST_EVICT;
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				if (sts.pass_last) begin
					state_nxt = ST_COMMIT;
				end else begin
					cmd.scan_init  = 1'b1;
					cmd.prune_mode = 1'b1;
					state_nxt      = ST_PRUNE;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/plrc_dp.sv =====
// datapath for the pair-keyed lru cache: entry memories, scan trackers, counters
module plrc_dp #(
	parameter int TABLE_ENTRIES = 64,
	parameter int PRUNE_COUNT   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  plrc_pkg::req_t      req,
	input  plrc_pkg::ctl_cmd_t  cmd,
	output plrc_pkg::ctl_sts_t  sts,
	output logic                done,
	output plrc_pkg::rsp_t      rsp
);
	import plrc_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int PASSES = (PRUNE_COUNT < TABLE_ENTRIES) ? PRUNE_COUNT : TABLE_ENTRIES;
	localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;

	// entry memories
	logic               val_mem    [TABLE_ENTRIES];
	logic [KEY_W-1:0]   key_mem    [TABLE_ENTRIES];
	logic [STAMP_W-1:0] stamp_mem  [TABLE_ENTRIES];
	logic [ID_W-1:0]    layout_mem [TABLE_ENTRIES];

	// registered read data
	logic               val_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic [ID_W-1:0]    layout_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               rd_vld_s1;

	logic [IDX_W-1:0]   addr_q;
	logic               mode_q;
	logic [KEY_W-1:0]   key_q;

	// lookup trackers
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [ID_W-1:0]    hit_layout_q;
	logic [CNT_W-1:0]   used_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	// prune trackers
	logic               vic_q;
	logic [IDX_W-1:0]   vic_idx_q;
	logic [STAMP_W-1:0] min_q;
	logic               ev_q;
	logic [IDX_W-1:0]   ev_idx_q;
	logic [PASS_W-1:0]  pass_q;

	logic [STAMP_W-1:0] use_q;
	logic [ID_W-1:0]    next_layout_q;
	logic               warned_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic               val_we;
	logic [IDX_W-1:0]   val_wa;
	logic               val_wd;
	logic [IDX_W-1:0]   slot;
	logic [STAMP_W-1:0] stamp_new;
	logic               pruned;

	// status
	assign sts.addr_last = (addr_q == IDX_W'(TABLE_ENTRIES - 1));
	assign sts.hit       = hit_q;
	assign sts.full      = (used_q == CNT_W'(TABLE_ENTRIES));
	assign sts.pass_last = (pass_q == PASS_W'(PASSES - 1));

	// commit slot and stamp
	assign pruned    = !hit_q && sts.full;
	assign slot      = hit_q ? hit_idx_q : (pruned ? ev_idx_q : free_idx_q);
	assign stamp_new = hit_q ? (use_q + STAMP_W'(1)) : (use_q + STAMP_W'(2));

	// valid bit write port
	always_comb begin
		val_we = 1'b0;
		val_wa = addr_q;
		val_wd = 1'b0;
		if (cmd.clear) begin
			val_we = 1'b1;
		end else if (cmd.evict && vic_q) begin
			val_we = 1'b1;
			val_wa = vic_idx_q;
		end else if (cmd.commit && !hit_q) begin
			val_we = 1'b1;
			val_wa = slot;
			val_wd = 1'b1;
		end
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_wa] <= val_wd;
		end
		if (cmd.commit) begin
			stamp_mem[slot] <= stamp_new;
		end
		if (cmd.commit && !hit_q) begin
			key_mem[slot]    <= key_q;
			layout_mem[slot] <= next_layout_q;
		end
		val_s1    <= val_mem[addr_q];
		key_s1    <= key_mem[addr_q];
		stamp_s1  <= stamp_mem[addr_q];
		layout_s1 <= layout_mem[addr_q];
		idx_s1    <= addr_q;
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.scan_init && !cmd.prune_mode) begin
			key_q <= {req.buffer_decl_id, req.shader_decl_id};
		end
		if (cmd.commit) begin
			rsp_q.hit         <= hit_q;
			rsp_q.layout_id   <= hit_q ? hit_layout_q : next_layout_q;
			rsp_q.pruned      <= pruned;
			rsp_q.first_prune <= pruned && !warned_q;
		end
	end

	// scan address, trackers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q        <= '0;
			rd_vld_s1     <= 1'b0;
			mode_q        <= 1'b0;
			hit_q         <= 1'b0;
			hit_idx_q     <= '0;
			hit_layout_q  <= '0;
			used_q        <= '0;
			free_q        <= 1'b0;
			free_idx_q    <= '0;
			vic_q         <= 1'b0;
			vic_idx_q     <= '0;
			min_q         <= '0;
			ev_q          <= 1'b0;
			ev_idx_q      <= '0;
			pass_q        <= '0;
			use_q         <= '0;
			next_layout_q <= ID_W'(1);
			warned_q      <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			done_q    <= cmd.commit;

			// scan address
			if (cmd.scan_init) begin
				addr_q <= '0;
				mode_q <= cmd.prune_mode;
				vic_q  <= 1'b0;
				if (!cmd.prune_mode) begin
					hit_q  <= 1'b0;
					used_q <= '0;
					free_q <= 1'b0;
					ev_q   <= 1'b0;
					pass_q <= '0;
				end
			end else if (cmd.scan || cmd.clear) begin
				addr_q <= sts.addr_last ? '0 : addr_q + IDX_W'(1);
			end

			// compare stage on read data
			if (rd_vld_s1 && !mode_q) begin
				if (val_s1) begin
					used_q <= used_q + CNT_W'(1);
					if (!hit_q && key_s1 == key_q) begin
						hit_q        <= 1'b1;
						hit_idx_q    <= idx_s1;
						hit_layout_q <= layout_s1;
					end
				end else if (!free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
			if (rd_vld_s1 && mode_q) begin
				if (val_s1 && (!vic_q || stamp_s1 < min_q)) begin
					vic_q     <= 1'b1;
					vic_idx_q <= idx_s1;
					min_q     <= stamp_s1;
				end
			end

			// eviction keeps the lowest freed slot
			if (cmd.evict) begin
				pass_q <= pass_q + PASS_W'(1);
				if (vic_q && (!ev_q || vic_idx_q < ev_idx_q)) begin
					ev_q     <= 1'b1;
					ev_idx_q <= vic_idx_q;
				end
			end

			// global counters
			if (cmd.commit) begin
				use_q <= stamp_new;
				if (!hit_q) begin
					next_layout_q <= next_layout_q + ID_W'(1);
				end
				if (pruned) begin
					warned_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/pair_keyed_lru_cache_batch_prune.sv =====
// a lookup scans every entry, one entry read per cycle, then decides and commits; done is registered from the commit
// a miss on a full table adds one full min-stamp scan of the stamp memory per evicted entry,
// for min(PRUNE_COUNT, TABLE_ENTRIES) evicted entries in all
// one lookup at a time: start is taken only while busy is low
// reset: async active low; a clearing pass over all entries holds busy high
// here the receiver cannot stall: done is a one-cycle strobe
module pair_keyed_lru_cache_batch_prune #(
	parameter int TABLE_ENTRIES = 64,
	parameter int PRUNE_COUNT   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  plrc_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output plrc_pkg::rsp_t  rsp
);
	import plrc_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// controller
	plrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	plrc_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.PRUNE_COUNT   (PRUNE_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

	// accepted beat keeps the block busy next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted beat");

	// result strobe only follows a commit
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.commit))
		else $error("done without commit");

	// first prune flag implies a prune
	a_first_implies_pruned: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.first_prune |-> rsp.pruned)
		else $error("first_prune without pruned");

	// a hit never evicts
	a_hit_no_prune: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.hit |-> !rsp.pruned)
		else $error("pruned on a hit");

endmodule
